// ===== hdl/hcrc_pkg.sv =====
`timescale 1ns / 1ps
// Package for the hit-count replacement cache: sizes, request codes, the
// top's word types, and the scan token, write command and release types
// shared by the cell and top. Depends on nothing.
package hcrc_pkg;

   localparam int SLOT_COUNT  = 8;
   localparam int ID_BITS     = 16;
   localparam int HANDLE_BITS = 32;
   localparam int COUNT_BITS  = 16;
   localparam int IDX_BITS    = $clog2(SLOT_COUNT);

   localparam logic [1:0] REQ_LOOKUP = 2'd0;
   localparam logic [1:0] REQ_INSERT = 2'd1;
   localparam logic [1:0] REQ_CLEAR  = 2'd2;

   typedef struct packed {
      logic [1:0]             req_type;
      logic [ID_BITS-1:0]     media_id;
      logic [HANDLE_BITS-1:0] image_handle;
   } hcrc_req_word_type;

   typedef struct packed {
      logic                   hit;
      logic [IDX_BITS-1:0]    slot_index;
      logic [HANDLE_BITS-1:0] retained_handle;
      logic                   release_valid;
      logic [HANDLE_BITS-1:0] release_handle;
      logic                   last_result;
   } hcrc_rsp_word_type;

   // Scan token that walks the row of cells, one cell per cycle.
   typedef struct packed {
      logic                   active;
      logic [1:0]             op;
      logic [ID_BITS-1:0]     media_id;
      logic                   hit_found;
      logic [IDX_BITS-1:0]    hit_idx;
      logic [HANDLE_BITS-1:0] hit_handle;
      logic                   empty_found;
      logic [IDX_BITS-1:0]    empty_idx;
      logic                   min_found;
      logic [IDX_BITS-1:0]    min_idx;
      logic [COUNT_BITS-1:0]  min_count;
      logic [HANDLE_BITS-1:0] min_handle;
   } hcrc_token_type;

   // Write command broadcast to all cells; only the addressed cell acts.
   typedef struct packed {
      logic                   en;
      logic                   incr;
      logic [IDX_BITS-1:0]    idx;
      logic [ID_BITS-1:0]     media_id;
      logic [HANDLE_BITS-1:0] handle;
   } hcrc_wr_type;

   typedef struct packed {
      logic                   valid;
      logic [IDX_BITS-1:0]    idx;
      logic [HANDLE_BITS-1:0] handle;
   } hcrc_rel_type;

endpackage

// ===== hdl/hcrc_cell.sv =====
`timescale 1ns / 1ps
// One slot of the cache: holds id, handle and hit count, updates the scan token
// as it passes and hands it on. Depends on hcrc_pkg.
module hcrc_cell
   import hcrc_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic [IDX_BITS-1:0] cell_index,
   input  hcrc_token_type      tok_prev,
   output hcrc_token_type      tok_next,
   input  hcrc_wr_type         wr,
   output hcrc_rel_type        rel
);

   logic                   valid_ff, valid_in;
   logic [ID_BITS-1:0]     asset_ff, asset_in;
   logic [HANDLE_BITS-1:0] handle_ff, handle_in;
   logic [COUNT_BITS-1:0]  count_ff, count_in;
   hcrc_token_type         tok_ff, tok_in;
   logic                   match;

   always_comb begin
      tok_in    = tok_prev;
      rel       = '0;
      valid_in  = valid_ff;
      asset_in  = asset_ff;
      handle_in = handle_ff;
      count_in  = count_ff;
      match     = valid_ff && (asset_ff == tok_prev.media_id);

      if (tok_prev.active) begin
         if (!tok_prev.hit_found && match) begin
            tok_in.hit_found  = 1'b1;
            tok_in.hit_idx    = cell_index;
            tok_in.hit_handle = handle_ff;
         end
         if (!tok_prev.empty_found && !valid_ff) begin
            tok_in.empty_found = 1'b1;
            tok_in.empty_idx   = cell_index;
         end
         // Strict compare keeps the lowest index on a tie.
         if (!tok_prev.min_found || (count_ff < tok_prev.min_count)) begin
            tok_in.min_found  = 1'b1;
            tok_in.min_idx    = cell_index;
            tok_in.min_count  = count_ff;
            tok_in.min_handle = handle_ff;
         end
         if (tok_prev.op == REQ_CLEAR) begin
            if (valid_ff) begin
               rel.valid  = 1'b1;
               rel.idx    = cell_index;
               rel.handle = handle_ff;
            end
            valid_in = 1'b0;
            count_in = '0;
         end
      end

      if (wr.en && (wr.idx == cell_index)) begin
         if (wr.incr) begin
            if (count_ff != {COUNT_BITS{1'b1}}) begin
               count_in = count_ff + COUNT_BITS'(1);
            end
         end else begin
            valid_in  = 1'b1;
            asset_in  = wr.media_id;
            handle_in = wr.handle;
            count_in  = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         count_ff <= '0;
         tok_ff   <= '0;
      end else begin
         valid_ff <= valid_in;
         count_ff <= count_in;
         tok_ff   <= tok_in;
      end
      asset_ff  <= asset_in;
      handle_ff <= handle_in;
   end

   assign tok_next = tok_ff;

endmodule

// ===== hdl/hit_count_replacement_cache.sv =====
`timescale 1ns / 1ps
// Hit-count replacement cache top level: row of slot cells plus the request
// sequencer and result register. Depends on hcrc_pkg and hcrc_cell.
//
// Usage: a request word (lookup, insert or clear) is taken at a rising edge
// where start is high and busy is low. Results leave on rsp_word, each valid
// for exactly one cycle while rsp_strobe is high; the receiver cannot stall
// them, so it must take every word as it comes. last_result marks the final
// word of a request.
// A lookup, a clear or an insert with a nonzero handle sends a scan token
// through the SLOT_COUNT cells, one cell per cycle; the token gathers the
// first match, the first empty slot and the lowest count as it goes.
// Lookup and insert: the result is registered once the token leaves the last
// cell. An insert or a lookup hit then writes the chosen slot, and busy
// stays high until that write is done; a lookup miss drops busy at the end
// of the scan.
// Clear: each held handle is released as the token passes its slot, and the
// last word follows the scan; busy stays high until the scan ends.
// An insert with a zero handle or an unused request code gives one empty
// result on the next cycle and leaves busy low.
// Reset empties every slot and drops any request in flight.
module hit_count_replacement_cache
   import hcrc_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  hcrc_req_word_type req_word,
   output logic              rsp_strobe,
   output hcrc_rsp_word_type rsp_word
);

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_SCAN = 1'b1;

   logic                   state_ff, state_in;
   hcrc_req_word_type      req_ff, req_in;
   hcrc_wr_type            wr_ff, wr_in;
   logic                   rsp_strobe_ff, rsp_strobe_in;
   hcrc_rsp_word_type      rsp_ff, rsp_in;
   hcrc_rel_type           pend_ff, pend_in;

   hcrc_token_type         tok_chain [SLOT_COUNT+1];
   hcrc_rel_type           rel_cell  [SLOT_COUNT];
   hcrc_rel_type           rel_any;
   hcrc_token_type         tail;
   logic [SLOT_COUNT-1:0]  tok_active_vec;
   logic [SLOT_COUNT-1:0]  rel_valid_vec;
   logic                   accept;
   logic                   scan_op;
   logic                   evict;
   logic [IDX_BITS-1:0]    pick;

   assign busy   = (state_ff == ST_SCAN) || wr_ff.en;
   assign accept = start && !busy;
   assign tail   = tok_chain[SLOT_COUNT];

   always_comb begin
      scan_op = (req_word.req_type == REQ_LOOKUP) || (req_word.req_type == REQ_CLEAR) ||
                ((req_word.req_type == REQ_INSERT) && (req_word.image_handle != '0));
      tok_chain[0]          = '0;
      tok_chain[0].active   = accept && scan_op;
      tok_chain[0].op       = req_word.req_type;
      tok_chain[0].media_id = req_word.media_id;
   end

   for (genvar gi = 0; gi < SLOT_COUNT; gi++) begin : g_cell
      hcrc_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .cell_index (IDX_BITS'(gi)),
         .tok_prev   (tok_chain[gi]),
         .tok_next   (tok_chain[gi+1]),
         .wr         (wr_ff),
         .rel        (rel_cell[gi])
      );
      assign tok_active_vec[gi] = tok_chain[gi+1].active;
      assign rel_valid_vec[gi]  = rel_cell[gi].valid;
   end

   // Only the cell holding the token can release, so the lanes merge by OR.
   always_comb begin
      rel_any = '0;
      for (int i = 0; i < SLOT_COUNT; i++) begin
         rel_any = rel_any | rel_cell[i];
      end
   end

   always_comb begin
      evict = !tail.hit_found && !tail.empty_found;
      if (tail.hit_found) begin
         pick = tail.hit_idx;
      end else if (tail.empty_found) begin
         pick = tail.empty_idx;
      end else begin
         pick = tail.min_idx;
      end
   end

   always_comb begin
      state_in      = state_ff;
      req_in        = req_ff;
      wr_in         = '0;
      rsp_strobe_in = 1'b0;
      rsp_in        = '0;
      pend_in       = pend_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               req_in = req_word;
               if (scan_op) begin
                  state_in = ST_SCAN;
                  // The first cell sees the token in the accept cycle itself.
                  pend_in  = rel_any;
               end else begin
                  rsp_strobe_in      = 1'b1;
                  rsp_in.last_result = 1'b1;
               end
            end
         end
         ST_SCAN: begin
            // A clear holds back one release word so the final one can carry last_result.
            if (rel_any.valid) begin
               if (pend_ff.valid) begin
                  rsp_strobe_in         = 1'b1;
                  rsp_in.slot_index     = pend_ff.idx;
                  rsp_in.release_valid  = 1'b1;
                  rsp_in.release_handle = pend_ff.handle;
               end
               pend_in = rel_any;
            end
            if (tail.active) begin
               state_in           = ST_IDLE;
               rsp_strobe_in      = 1'b1;
               rsp_in             = '0;
               rsp_in.last_result = 1'b1;
               priority if (req_ff.req_type == REQ_LOOKUP) begin
                  if (tail.hit_found) begin
                     wr_in.en               = 1'b1;
                     wr_in.incr             = 1'b1;
                     wr_in.idx              = tail.hit_idx;
                     rsp_in.hit             = 1'b1;
                     rsp_in.slot_index      = tail.hit_idx;
                     rsp_in.retained_handle = tail.hit_handle;
                  end
               end else if (req_ff.req_type == REQ_INSERT) begin
                  wr_in.en          = 1'b1;
                  wr_in.incr        = 1'b0;
                  wr_in.idx         = pick;
                  wr_in.media_id    = req_ff.media_id;
                  wr_in.handle      = req_ff.image_handle;
                  rsp_in.slot_index = pick;
                  if (tail.hit_found) begin
                     rsp_in.release_valid  = 1'b1;
                     rsp_in.release_handle = tail.hit_handle;
                  end else if (evict) begin
                     rsp_in.release_valid  = 1'b1;
                     rsp_in.release_handle = tail.min_handle;
                  end
               end else begin
                  if (pend_ff.valid) begin
                     rsp_in.slot_index     = pend_ff.idx;
                     rsp_in.release_valid  = 1'b1;
                     rsp_in.release_handle = pend_ff.handle;
                  end
                  pend_in.valid = 1'b0;
               end
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         wr_ff         <= '0;
         rsp_strobe_ff <= 1'b0;
         pend_ff       <= '0;
      end else begin
         state_ff      <= state_in;
         wr_ff         <= wr_in;
         rsp_strobe_ff <= rsp_strobe_in;
         pend_ff       <= pend_in;
      end
      req_ff <= req_in;
      rsp_ff <= rsp_in;
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_word   = rsp_ff;

   a_single_token : assert property (@(posedge clock) disable iff (reset)
      $onehot0(tok_active_vec))
      else $error("more than one scan token in the cell row");

   a_single_release : assert property (@(posedge clock) disable iff (reset)
      $onehot0(rel_valid_vec))
      else $error("two cells released a handle in the same cycle");

   a_tail_in_scan : assert property (@(posedge clock) disable iff (reset)
      tail.active |-> (state_ff == ST_SCAN))
      else $error("scan token finished while the sequencer was idle");

   a_write_no_scan : assert property (@(posedge clock) disable iff (reset)
      wr_ff.en |-> ((tok_active_vec == '0) && !tok_chain[0].active))
      else $error("slot write overlaps a scan");

   a_hit_no_release : assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_word.hit) |-> (!rsp_word.release_valid && rsp_word.last_result))
      else $error("lookup hit word carries a release");

endmodule
